### hdl/adc_average_linearize_level_macros.svh
// Assertion macros for the level conditioner top level.
// Needs a clk and an active-high rst signal in the including scope.
`ifndef ADC_AVERAGE_LINEARIZE_LEVEL_MACROS_SVH
`define ADC_AVERAGE_LINEARIZE_LEVEL_MACROS_SVH

// same-cycle implication
`define AAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/aalvl_pkg.sv
// Shared types, constants and helpers of the level conditioner.
// No dependencies.
package aalvl_pkg;

  localparam int PT_W       = 12;
  localparam int PCT_W      = 7;
  localparam int CLS_W      = 2;
  localparam int NUM_POINTS = 5;
  localparam int NUM_TH     = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 17;

  localparam logic [PCT_W-1:0] SEG_STEP = 7'd25;
  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [CLS_W-1:0] CLASS_LOW    = 2'd0;
  localparam logic [CLS_W-1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLASS_HIGH   = 2'd2;
  localparam logic [CLS_W-1:0] CLASS_DANGER = 2'd3;

  localparam logic [2:0] REG_POINT_ZERO   = 3'd0;
  localparam logic [2:0] REG_POINT_QUART  = 3'd1;
  localparam logic [2:0] REG_POINT_HALF   = 3'd2;
  localparam logic [2:0] REG_POINT_3QUART = 3'd3;
  localparam logic [2:0] REG_POINT_FULL   = 3'd4;
  localparam logic [2:0] REG_TH_MEDIUM    = 3'd5;
  localparam logic [2:0] REG_TH_HIGH      = 3'd6;
  localparam logic [2:0] REG_TH_DANGER    = 3'd7;

  localparam logic [PT_W-1:0]  RST_POINT_ZERO   = 12'd0;
  localparam logic [PT_W-1:0]  RST_POINT_QUART  = 12'd1850;
  localparam logic [PT_W-1:0]  RST_POINT_HALF   = 12'd2000;
  localparam logic [PT_W-1:0]  RST_POINT_3QUART = 12'd2150;
  localparam logic [PT_W-1:0]  RST_POINT_FULL   = 12'd2300;
  localparam logic [PCT_W-1:0] RST_TH_MEDIUM    = 7'd30;
  localparam logic [PCT_W-1:0] RST_TH_HIGH      = 7'd70;
  localparam logic [PCT_W-1:0] RST_TH_DANGER    = 7'd90;

  typedef struct packed {
    logic [NUM_POINTS-1:0][PT_W-1:0] point;
    logic [NUM_TH-1:0][PCT_W-1:0]    thresh;
  } cal_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AVG,
    BK_SEG,
    BK_PCT,
    BK_OUT
  } back_state_t;

  function automatic logic [CLS_W-1:0] level_of(
    input logic [PCT_W-1:0] pct,
    input logic [NUM_TH-1:0][PCT_W-1:0] th
  );
    logic [CLS_W-1:0] cls;
    priority if (pct < th[0]) cls = CLASS_LOW;
    else if (pct < th[1]) cls = CLASS_MEDIUM;
    else if (pct < th[2]) cls = CLASS_HIGH;
    else cls = CLASS_DANGER;
    return cls;
  endfunction

endpackage

### hdl/aalvl_front.sv
// Front end: takes sample beats, accumulates each group and queues its sum.
// Depends on aalvl_pkg.
module aalvl_front import aalvl_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 10,
  parameter int SUM_W = 17,
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [PT_W-1:0]  sample,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  logic             q_full,
  output logic             push,
  output logic [SUM_W-1:0] push_sum
);

  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic [CNT_W-1:0] samples_taken;
  logic             accept;
  logic             last;

  assign sample_ready     = !q_full;
  assign accept           = sample_valid && sample_ready;
  assign last             = (samples_taken == CNT_W'(SAMPLES_PER_GROUP - 1));
  assign running_sum_next = running_sum + SUM_W'(sample);
  assign push             = accept && last;
  assign push_sum         = running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      samples_taken <= '0;
    end else if (accept) begin
      if (last) begin
        running_sum   <= '0;
        samples_taken <= '0;
      end else begin
        running_sum   <= running_sum_next;
        samples_taken <= samples_taken + CNT_W'(1);
      end
    end
  end

endmodule

### hdl/aalvl_fifo.sv
// Two-entry queue of group sums between front and back end.
// Depends on aalvl_pkg.
module aalvl_fifo import aalvl_pkg::*; #(
  parameter int SUM_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [SUM_W-1:0] push_sum,
  input  logic             pop,
  output logic [SUM_W-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [1:0][SUM_W-1:0] mem;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### hdl/aalvl_div.sv
// Restoring divider, one quotient bit per cycle, used by the back end.
// Depends on aalvl_pkg.
module aalvl_div import aalvl_pkg::*; #(
  parameter int DVD_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [PT_W-1:0]  divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [PT_W-1:0]   rem;
  logic [PT_W-1:0]   dvs;
  logic [DVD_W-1:0]  quo;
  logic [PT_W:0]     shifted;
  logic [PT_W+1:0]   diff;
  logic              ge;

  assign shifted  = {rem, quo[DVD_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs};
  assign ge       = !diff[PT_W+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[PT_W-1:0] : shifted[PT_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### hdl/aalvl_back.sv
// Back end: averages a queued sum, maps it to percent and class, holds the result.
// Depends on aalvl_pkg and aalvl_div.
module aalvl_back import aalvl_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 10,
  parameter int SUM_W = 17,
  parameter int DVD_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  cal_cfg_t          cfg,
  input  logic [SUM_W-1:0]  q_sum,
  input  logic              q_empty,
  output logic              pop,
  output logic [PT_W-1:0]   average_reading,
  output logic [PCT_W-1:0]  fill_percent,
  output logic [CLS_W-1:0]  level_class,
  output logic              result_valid,
  input  logic              result_ready
);

  // mean by reciprocal multiply, exact for every sum below 2**SUM_W
  localparam int     REC_L   = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 0;
  localparam int     REC_SH  = SUM_W + REC_L;
  localparam int     MUL_W   = 2 * SUM_W + 1;
  localparam longint REC_MUL = ((longint'(1) << REC_SH) + longint'(SAMPLES_PER_GROUP) - 1)
                               / longint'(SAMPLES_PER_GROUP);

  back_state_t state;
  back_state_t state_next;

  logic [PT_W-1:0]   avg;
  logic [PCT_W-1:0]  base;
  logic [SUM_W-1:0]  grp_sum;
  logic [MUL_W-1:0]  mean_prod;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [PT_W-1:0]   div_divisor;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic              ld_sum;
  logic              ld_avg;
  logic              ld_seg;
  logic              ld_out;

  logic              seg_interp;
  logic [PCT_W-1:0]  seg_fixed;
  logic [PCT_W-1:0]  seg_base;
  logic [PT_W-1:0]   seg_lo;
  logic [PT_W-1:0]   seg_hi;
  logic [PT_W-1:0]   delta;
  logic [PT_W-1:0]   span;
  logic [PROD_W-1:0] prod;
  logic [PCT_W-1:0]  out_pct;

  aalvl_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // segment pick: first upper point at or above the mean; 0 at or below point 0, 100 above point 4
  always_comb begin
    seg_interp = 1'b1;
    seg_fixed  = PCT_ZERO;
    seg_base   = PCT_ZERO;
    seg_lo     = cfg.point[0];
    seg_hi     = cfg.point[1];
    priority if (avg <= cfg.point[0]) begin
      seg_interp = 1'b0;
      seg_fixed  = PCT_ZERO;
    end else if (avg <= cfg.point[1]) begin
      seg_base = PCT_ZERO;
      seg_lo   = cfg.point[0];
      seg_hi   = cfg.point[1];
    end else if (avg <= cfg.point[2]) begin
      seg_base = SEG_STEP;
      seg_lo   = cfg.point[1];
      seg_hi   = cfg.point[2];
    end else if (avg <= cfg.point[3]) begin
      seg_base = PCT_W'(SEG_STEP * 2);
      seg_lo   = cfg.point[2];
      seg_hi   = cfg.point[3];
    end else if (avg <= cfg.point[4]) begin
      seg_base = PCT_W'(SEG_STEP * 3);
      seg_lo   = cfg.point[3];
      seg_hi   = cfg.point[4];
    end else begin
      seg_interp = 1'b0;
      seg_fixed  = PCT_FULL;
    end
  end

  assign mean_prod = MUL_W'(grp_sum) * MUL_W'(REC_MUL);
  assign delta     = avg - seg_lo;
  assign span      = seg_hi - seg_lo;
  assign prod      = PROD_W'(delta) * PROD_W'(SEG_STEP);
  assign out_pct   = (state == BK_PCT) ? (div_quo[PCT_W-1:0] + base) : seg_fixed;

  assign result_valid = (state == BK_OUT);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_AVG;
      BK_AVG:  state_next = BK_SEG;
      BK_SEG:  state_next = seg_interp ? BK_PCT : BK_OUT;
      BK_PCT:  if (div_done) state_next = BK_OUT;
      BK_OUT:  if (result_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = DVD_W'(prod);
    div_divisor  = span;
    ld_sum       = 1'b0;
    ld_avg       = 1'b0;
    ld_seg       = 1'b0;
    ld_out       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop    = !q_empty;
        ld_sum = !q_empty;
      end
      BK_AVG: begin
        ld_avg = 1'b1;
      end
      BK_SEG: begin
        ld_seg    = 1'b1;
        div_start = seg_interp;
        ld_out    = !seg_interp;
      end
      BK_PCT: begin
        ld_out = div_done;
      end
      BK_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_sum) begin
      grp_sum <= q_sum;
    end
    if (ld_avg) begin
      avg <= mean_prod[REC_SH +: PT_W];
    end
    if (ld_seg) begin
      base <= seg_base;
    end
    if (ld_out) begin
      average_reading <= avg;
      fill_percent    <= out_pct;
      level_class     <= level_of(out_pct, cfg.thresh);
    end
  end

endmodule

### hdl/adc_average_linearize_level.sv
// Top level of the level-sensor conditioner: register port, front, queue, back.
// Depends on aalvl_pkg, aalvl_front, aalvl_fifo, aalvl_back and the macro header.
//
//   channel   handshake                    payload
//   sample    sample_valid / sample_ready  sample
//   result    result_valid / result_ready  average_reading, fill_percent, level_class
//   config    psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// A sample beat is taken whenever the two-entry sum queue is not full; the front stalls only when it is full.
// Back per group: pop, reciprocal mean, segment pick, then the serial interpolation divide
// when the mean lies inside a segment, before the result shows.
// Reset is synchronous; registers return to their calibration defaults, no clearing pass.
// A result waiting on result_ready stalls only the back; the front runs until the queue fills.
`include "adc_average_linearize_level_macros.svh"

module adc_average_linearize_level import aalvl_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [PT_W-1:0]    sample,
  input  logic               sample_valid,
  output logic               sample_ready,
  output logic [PT_W-1:0]    average_reading,
  output logic [PCT_W-1:0]   fill_percent,
  output logic [CLS_W-1:0]   level_class,
  output logic               result_valid,
  input  logic               result_ready,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int SUM_W = $clog2(SAMPLES_PER_GROUP * 4095 + 1);
  localparam int CNT_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
  localparam int DVD_W = PROD_W;

  cal_cfg_t         cfg;
  logic [2:0]       reg_idx;
  logic             wr_en;
  logic             q_push;
  logic [SUM_W-1:0] q_push_sum;
  logic             q_pop;
  logic [SUM_W-1:0] q_head;
  logic             q_full;
  logic             q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point[0]  <= RST_POINT_ZERO;
      cfg.point[1]  <= RST_POINT_QUART;
      cfg.point[2]  <= RST_POINT_HALF;
      cfg.point[3]  <= RST_POINT_3QUART;
      cfg.point[4]  <= RST_POINT_FULL;
      cfg.thresh[0] <= RST_TH_MEDIUM;
      cfg.thresh[1] <= RST_TH_HIGH;
      cfg.thresh[2] <= RST_TH_DANGER;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POINT_ZERO:   cfg.point[0]  <= pwdata[PT_W-1:0];
        REG_POINT_QUART:  cfg.point[1]  <= pwdata[PT_W-1:0];
        REG_POINT_HALF:   cfg.point[2]  <= pwdata[PT_W-1:0];
        REG_POINT_3QUART: cfg.point[3]  <= pwdata[PT_W-1:0];
        REG_POINT_FULL:   cfg.point[4]  <= pwdata[PT_W-1:0];
        REG_TH_MEDIUM:    cfg.thresh[0] <= pwdata[PCT_W-1:0];
        REG_TH_HIGH:      cfg.thresh[1] <= pwdata[PCT_W-1:0];
        REG_TH_DANGER:    cfg.thresh[2] <= pwdata[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POINT_ZERO:   prdata = DATA_W'(cfg.point[0]);
      REG_POINT_QUART:  prdata = DATA_W'(cfg.point[1]);
      REG_POINT_HALF:   prdata = DATA_W'(cfg.point[2]);
      REG_POINT_3QUART: prdata = DATA_W'(cfg.point[3]);
      REG_POINT_FULL:   prdata = DATA_W'(cfg.point[4]);
      REG_TH_MEDIUM:    prdata = DATA_W'(cfg.thresh[0]);
      REG_TH_HIGH:      prdata = DATA_W'(cfg.thresh[1]);
      REG_TH_DANGER:    prdata = DATA_W'(cfg.thresh[2]);
      default:          prdata = '0;
    endcase
  end

  aalvl_front #(
    .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
    .SUM_W             (SUM_W),
    .CNT_W             (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .q_full       (q_full),
    .push         (q_push),
    .push_sum     (q_push_sum)
  );

  aalvl_fifo #(.SUM_W(SUM_W)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_sum (q_push_sum),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  aalvl_back #(
    .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
    .SUM_W             (SUM_W),
    .DVD_W             (DVD_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_sum           (q_head),
    .q_empty         (q_empty),
    .pop             (q_pop),
    .average_reading (average_reading),
    .fill_percent    (fill_percent),
    .level_class     (level_class),
    .result_valid    (result_valid),
    .result_ready    (result_ready)
  );

  `AAL_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "group sum pushed into full queue")
  `AAL_ASSERT_NOW(a_pct_range, result_valid, fill_percent <= PCT_FULL, "fill percent above 100")
  `AAL_ASSERT_NEXT(a_pop_starts_work, q_pop, !result_valid, "result shown right after pop")

endmodule

### tb/adc_average_linearize_level_test.sv
// Testbench for adc_average_linearize_level: random sample beats in groups, APB calibration sets.
// Predicts group mean, fill percent and level class and checks each result beat in order.
// Depends on aalvl_pkg and the adc_average_linearize_level RTL.
`timescale 1ns / 1ps

module adc_average_linearize_level_test;
  import aalvl_pkg::*;

  localparam int GROUP_LEN   = 10;
  localparam int MAX_READING = (1 << PT_W) - 1;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 70;
  localparam int SETTLE      = 100;
  localparam int LIMIT       = 400000;

  typedef struct packed {
    logic [PT_W-1:0]  mean;
    logic [PCT_W-1:0] pct;
    logic [CLS_W-1:0] cls;
  } level_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [PT_W-1:0]    sample = '0;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  logic [PT_W-1:0]    average_reading;
  logic [PCT_W-1:0]   fill_percent;
  logic [CLS_W-1:0]   level_class;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  adc_average_linearize_level #(.SAMPLES_PER_GROUP(GROUP_LEN)) u_dut (
    .clk(clk), .rst(rst),
    .sample(sample), .sample_valid(sample_valid), .sample_ready(sample_ready),
    .average_reading(average_reading), .fill_percent(fill_percent),
    .level_class(level_class), .result_valid(result_valid), .result_ready(result_ready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // calibration shadow
  logic [PT_W-1:0]  cal_point [NUM_POINTS] = '{RST_POINT_ZERO, RST_POINT_QUART,
                                               RST_POINT_HALF, RST_POINT_3QUART,
                                               RST_POINT_FULL};
  logic [PCT_W-1:0] cal_th [NUM_TH] = '{RST_TH_MEDIUM, RST_TH_HIGH, RST_TH_DANGER};
  int               plan_point [NUM_POINTS];
  int               plan_th [NUM_TH];

  logic [PT_W-1:0]  pending_samples [$];
  level_result_t    expected_levels [$];
  int               group_sum = 0;
  int               group_count = 0;
  int               samples_pushed = 0;
  int               samples_accepted = 0;
  int               levels_checked = 0;
  int               writes_done = 0;
  int               error_count = 0;
  int               send_gap = 0;
  int               stall_left = 0;
  int               cycle_count = 0;
  bit               no_idle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic level_result_t expected_level(input int total);
    level_result_t r;
    int            mean;
    int            lo;
    int            span;
    int            pct;
    bit            found;
    mean  = total / GROUP_LEN;
    found = 1'b0;
    if (mean <= int'(cal_point[0])) begin
      pct = int'(PCT_ZERO);
    end else begin
      pct = int'(PCT_FULL);
      for (int k = 1; k < NUM_POINTS; k++) begin
        if (!found && mean <= int'(cal_point[k])) begin
          found = 1'b1;
          lo    = int'(cal_point[k-1]);
          span  = int'(cal_point[k]) - lo;
          pct   = (mean - lo) * int'(SEG_STEP) / span + (k - 1) * int'(SEG_STEP);
        end
      end
    end
    r.mean = PT_W'(mean);
    r.pct  = PCT_W'(pct);
    if (r.pct < cal_th[0]) r.cls = CLASS_LOW;
    else if (r.pct < cal_th[1]) r.cls = CLASS_MEDIUM;
    else if (r.pct < cal_th[2]) r.cls = CLASS_HIGH;
    else r.cls = CLASS_DANGER;
    return r;
  endfunction

  // sample driver and level predictor
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        group_sum += int'(sample);
        group_count++;
        samples_accepted++;
        if (group_count == GROUP_LEN) begin
          expected_levels.push_back(expected_level(group_sum));
          group_sum   = 0;
          group_count = 0;
        end
        send_gap = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!sample_valid || sample_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample       <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_levels.size() == 0) begin
          $error("result beat with nothing expected: average_reading %0d", average_reading);
          error_count++;
        end else begin
          level_result_t want;
          want = expected_levels.pop_front();
          levels_checked++;
          if (average_reading !== want.mean) begin
            $error("average_reading: expected %0d, got %0d", want.mean, average_reading);
            error_count++;
          end
          if (fill_percent !== want.pct) begin
            $error("fill_percent: expected %0d, got %0d", want.pct, fill_percent);
            error_count++;
          end
          if (level_class !== want.cls) begin
            $error("level_class: expected %0d, got %0d", want.cls, level_class);
            error_count++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  function automatic int push_sample(input int v);
    int s;
    s = v < 0 ? 0 : (v > MAX_READING ? MAX_READING : v);
    pending_samples.push_back(PT_W'(s));
    samples_pushed++;
    return s;
  endfunction

  task automatic queue_group();
    int goal;
    int spread;
    int rem;
    int partial;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, GROUP_LEN - 1)) void'(push_sample($urandom_range(0, MAX_READING)));
    end
    while (samples_pushed % GROUP_LEN != 0) void'(push_sample($urandom_range(0, MAX_READING)));
    if ($urandom_range(0, 4) == 0) begin
      repeat (GROUP_LEN) void'(push_sample($urandom_range(0, MAX_READING)));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          goal = int'(cal_point[$urandom_range(0, NUM_POINTS - 1)]) +
                 int'($urandom_range(0, 2)) - 1;
        6: goal = 0;
        7: goal = MAX_READING;
        default: goal = $urandom_range(0, MAX_READING);
      endcase
      goal = goal < 0 ? 0 : (goal > MAX_READING ? MAX_READING : goal);
      case ($urandom_range(0, 2))
        0: spread = 0;
        1: spread = 8;
        default: spread = 300;
      endcase
      rem     = (goal == MAX_READING) ? 0 : $urandom_range(0, GROUP_LEN - 1);
      partial = 0;
      repeat (GROUP_LEN - 1) begin
        partial += push_sample(goal + int'($urandom_range(0, 2 * spread)) - spread);
      end
      void'(push_sample(goal * GROUP_LEN + rem - partial));
    end
  endtask

  task automatic apb_write(input logic [2:0] idx, input int field);
    logic [DATA_W-1:0] word;
    word = $urandom;
    if (idx <= REG_POINT_FULL) word[PT_W-1:0] = PT_W'(field);
    else word[PCT_W-1:0] = PCT_W'(field);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_POINT_FULL) cal_point[idx] = word[PT_W-1:0];
    else cal_th[idx - REG_TH_MEDIUM] = word[PCT_W-1:0];
    writes_done++;
  endtask

  task automatic set_calibration(input int phase);
    int pick [$];
    int pool [3];
    case (phase)
      1: begin
        plan_point = '{0, 0, 0, 0, 0};
        plan_th    = '{0, 0, 0};
      end
      2: begin
        plan_point = '{MAX_READING, MAX_READING, MAX_READING, MAX_READING, MAX_READING};
        plan_th    = '{127, 127, 127};
      end
      3: begin
        plan_point = '{0, 1, 2, MAX_READING - 1, MAX_READING};
        plan_th    = '{101, 101, 101};
      end
      NUM_PHASES - 1: begin
        plan_point = '{int'(RST_POINT_ZERO), int'(RST_POINT_QUART), int'(RST_POINT_HALF),
                       int'(RST_POINT_3QUART), int'(RST_POINT_FULL)};
        plan_th    = '{int'(RST_TH_MEDIUM), int'(RST_TH_HIGH), int'(RST_TH_DANGER)};
      end
      default: begin
        foreach (pool[i]) pool[i] = $urandom_range(0, MAX_READING);
        case ($urandom_range(0, 2))
          0: begin
            repeat (NUM_POINTS) pick.push_back($urandom_range(0, MAX_READING));
            pick.sort();
          end
          1: repeat (NUM_POINTS) pick.push_back($urandom_range(0, MAX_READING));
          default: begin
            repeat (NUM_POINTS) pick.push_back(pool[$urandom_range(0, 2)]);
            pick.sort();
          end
        endcase
        foreach (plan_point[i]) plan_point[i] = pick[i];
        pick.delete();
        if ($urandom_range(0, 1) == 0) begin
          repeat (NUM_TH) pick.push_back($urandom_range(0, 101));
          pick.sort();
        end else begin
          repeat (NUM_TH) pick.push_back($urandom_range(0, 127));
        end
        foreach (plan_th[i]) plan_th[i] = pick[i];
      end
    endcase
    apb_write(REG_POINT_ZERO, plan_point[0]);
    apb_write(REG_POINT_QUART, plan_point[1]);
    apb_write(REG_POINT_HALF, plan_point[2]);
    apb_write(REG_POINT_3QUART, plan_point[3]);
    apb_write(REG_POINT_FULL, plan_point[4]);
    apb_write(REG_TH_MEDIUM, plan_th[0]);
    apb_write(REG_TH_HIGH, plan_th[1]);
    apb_write(REG_TH_DANGER, plan_th[2]);
  endtask

  // sender holds off until every beat is in and every result is out
  task automatic wait_idle();
    while (samples_accepted != samples_pushed || expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // full-scale group then empty group at reset calibration
    repeat (GROUP_LEN) void'(push_sample(MAX_READING));
    repeat (GROUP_LEN) void'(push_sample(0));
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        set_calibration(phase);
      end
      no_idle     = (phase % 3 == 2);
      phase_start = samples_pushed;
      while (samples_pushed - phase_start < PHASE_ITEMS) queue_group();
    end
    wait_idle();
    $display("covered %0d sample beats, %0d group results, %0d register writes, %0d cal sets",
             samples_accepted, levels_checked, writes_done, NUM_PHASES);
    if (error_count == 0) begin
      $display("adc_average_linearize_level_test: clean");
    end else begin
      $display("adc_average_linearize_level_test: errors");
    end
    $finish;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("adc_average_linearize_level_test: errors");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/aalvl_pkg.sv
hdl/aalvl_front.sv
hdl/aalvl_fifo.sv
hdl/aalvl_div.sv
hdl/aalvl_back.sv
hdl/adc_average_linearize_level.sv
tb/adc_average_linearize_level_test.sv
